[hdl/ssh_pkg.sv]
// Shared constants and types of the segment/sphere hit test.
package ssh_pkg;

	// Width of the radius register and its value after reset.
	localparam int RAD_W = 31;
	localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(65536);

	// Bits of the multiplier operand consumed per cycle by the serial multiplier.
	localparam int DIG = 4;

	// Configuration port layout.
	localparam int APB_DW = 32;
	localparam int APB_AW = 3;
	localparam logic REG_RADIUS = 1'b0;

	// Result of the comparisons made when an item finishes.
	typedef struct packed {
		logic hit;
		logic skipped;
		logic point_valid;
	} ssh_flags_t;

endpackage

[hdl/ssh_if.sv]
// Valid/ready channels for segment items and hit results.
interface ssh_seg_if #(
	parameter int W = 32
) ();
	logic valid;
	logic ready;
	logic signed [W-1:0] a_x;
	logic signed [W-1:0] a_y;
	logic signed [W-1:0] a_z;
	logic signed [W-1:0] b_x;
	logic signed [W-1:0] b_y;
	logic signed [W-1:0] b_z;
	logic signed [W-1:0] c_x;
	logic signed [W-1:0] c_y;
	logic signed [W-1:0] c_z;

	modport source (
		output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		input ready
	);
	modport sink (
		input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		output ready
	);
endinterface

interface ssh_res_if #(
	parameter int W = 32
) ();
	logic valid;
	logic ready;
	logic hit;
	logic skipped;
	logic point_valid;
	logic signed [W-1:0] p_x;
	logic signed [W-1:0] p_y;
	logic signed [W-1:0] p_z;

	modport source (
		output valid, hit, skipped, point_valid, p_x, p_y, p_z,
		input ready
	);
	modport sink (
		input valid, hit, skipped, point_valid, p_x, p_y, p_z,
		output ready
	);
endinterface

[hdl/ssh_apb.sv]
// APB register file holding the sphere radius.
module ssh_apb (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ssh_pkg::APB_AW-1:0] paddr,
	input  logic [ssh_pkg::APB_DW-1:0] pwdata,
	output logic [ssh_pkg::APB_DW-1:0] prdata,
	output logic                      pready,
	output logic [ssh_pkg::RAD_W-1:0]  radius
);
	import ssh_pkg::*;

	logic [RAD_W-1:0] radius_q;

	assign pready = 1'b1;
	assign radius = radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_RADIUS) begin
			radius_q <= pwdata[RAD_W-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == REG_RADIUS) begin
			prdata = APB_DW'(radius_q);
		end else begin
			prdata = '0;
		end
	end
endmodule

[hdl/ssh_mul.sv]
// Digit-serial unsigned multiplier, most significant digit first.
module ssh_mul #(
	parameter int MW = 33,
	parameter int PW = 69
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [MW-1:0] x,
	input  logic [MW-1:0] y,
	output logic          done,
	output logic [PW-1:0] prod
);
	import ssh_pkg::*;

	localparam int STEPS = (MW + DIG - 1) / DIG;
	localparam int MWP = STEPS * DIG;
	localparam int CW = $clog2(STEPS + 1);

	logic [MW-1:0]  x_q;
	logic [MWP-1:0] m_q;
	logic [PW-1:0]  p_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [PW-1:0]  part;

	// One partial product per cycle, folded in with a shift of one digit.
	assign part = PW'(x_q) * PW'(m_q[MWP-1 -: DIG]);
	assign done = done_q;
	assign prod = p_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
			m_q <= MWP'(y);
			p_q <= '0;
		end else if (busy_q) begin
			p_q <= (p_q << DIG) + part;
			m_q <= m_q << DIG;
		end
	end
endmodule

[hdl/ssh_div.sv]
// Restoring divider producing one quotient bit per cycle.
module ssh_div #(
	parameter int NW = 72,
	parameter int QW = 17
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [NW-1:0] den,
	output logic          done,
	output logic [QW-1:0] quot
);
	localparam int CW = $clog2(QW + 1);

	logic [NW:0]   rem_q;
	logic [NW:0]   den_q;
	logic [QW-1:0] q_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [NW:0]   trial;
	logic          take;

	// The first step compares the numerator as it is; later ones shift first.
	assign trial = (cnt_q == '0) ? rem_q : (rem_q << 1);
	assign take = trial >= den_q;
	assign done = done_q;
	assign quot = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= (NW+1)'(num);
			den_q <= (NW+1)'(den);
			q_q   <= '0;
		end else if (busy_q) begin
			rem_q <= take ? (trial - den_q) : trial;
			q_q   <= {q_q[QW-2:0], take};
		end
	end
endmodule

[hdl/segment_sphere_hit_test.sv]
// Top level of the segment/sphere hit test: sequencer, operand selection and result register.
//
// Usage. Segment items (endpoints A, B and sphere center C, signed fixed point
// with FRAC_BITS fraction bits) arrive on the seg channel; one result per item
// leaves on the result channel. A transfer happens on a clock edge with valid
// and ready both high. The radius register sits at APB byte address 0; writes
// take effect at the access cycle and must be made while the block is idle.
//
// Arithmetic. All products go through one digit-serial multiplier, 4
// multiplier bits per cycle, and the division through a one-bit-per-cycle
// divider; the multiplier operand width is MW = max(COORD_WIDTH+1, 31,
// FRAC_BITS+1). A tested item needs 13 products when the projection misses
// the segment, and 19 products and one division when it falls on it. While
// the hit latch is set an item is not tested and comes back as skipped.
// The sequencer works on one item at a time.
//
// Reset clears the hit latch, the sequencer and the output valid, and sets the
// radius to 65536 (1.0 at the default FRAC_BITS). A result waits in the output register while the receiver
// stalls; the next item may be transferred in meanwhile and is processed up to
// the point where its own result needs the register.
module segment_sphere_hit_test #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	ssh_seg_if.sink                   seg,
	ssh_res_if.source                 result,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ssh_pkg::APB_AW-1:0] paddr,
	input  logic [ssh_pkg::APB_DW-1:0] pwdata,
	output logic [ssh_pkg::APB_DW-1:0] prdata,
	output logic                      pready
);
	import ssh_pkg::*;

	localparam int W = COORD_WIDTH;
	localparam int F = FRAC_BITS;
	// Multiplier operand width: coordinate differences, the radius and t all fit.
	localparam int MW0 = (W + 1 > RAD_W) ? W + 1 : RAD_W;
	localparam int MW = (MW0 > F + 1) ? MW0 : F + 1;
	localparam int MWP = ((MW + DIG - 1) / DIG) * DIG;
	localparam int PW = MWP + MW;
	// Accumulator: room for a sum of three products and a sign.
	localparam int ACC = PW + 3;
	localparam int QW = F + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_WAIT,
		S_DIV,
		S_DWAIT,
		S_DONE
	} state_t;

	// Each job is a sum of products over the axes, one product for the radius, or for J_P one product per axis.
	typedef enum logic [2:0] {
		J_R2,
		J_SA,
		J_SB,
		J_LEN,
		J_DOT,
		J_P,
		J_SP
	} job_t;

	state_t state_q;
	job_t   job_q;
	logic [1:0] axis_q;

	logic signed [W-1:0] a_q [3];
	logic signed [W-1:0] b_q [3];
	logic signed [W-1:0] c_q [3];
	logic signed [W-1:0] p_q [3];

	logic [ACC-1:0] acc_q;
	logic [ACC-1:0] r2_q;
	logic [ACC-1:0] sa_q;
	logic [ACC-1:0] sb_q;
	logic [ACC-1:0] len_q;
	logic [ACC-1:0] dot_q;
	logic [ACC-1:0] sp_q;
	logic [QW-1:0]  tq_q;
	logic           skip_q;
	logic           point_q;
	logic           latch_q;

	logic           res_valid_q;
	ssh_flags_t     res_flags_q;
	logic signed [W-1:0] res_p_q [3];

	logic [RAD_W-1:0] radius;

	// Operand selection for the current job and axis.
	logic signed [W:0] e_ca;
	logic signed [W:0] e_cb;
	logic signed [W:0] e_d;
	logic signed [W:0] e_cp;
	logic [W:0] m_ca;
	logic [W:0] m_cb;
	logic [W:0] m_d;
	logic [W:0] m_cp;
	logic [MW-1:0] op_x;
	logic [MW-1:0] op_y;
	logic op_neg;

	logic mul_start;
	logic mul_done;
	logic [PW-1:0] prod;
	logic [ACC-1:0] prod_ext;
	logic [ACC-1:0] acc_next;
	logic [W:0] off;
	logic [W:0] p_next;
	logic last_axis;
	logic on_segment;

	logic div_start;
	logic div_done;
	logic [QW-1:0] quot;

	ssh_flags_t flags;
	logic out_free;

	ssh_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.radius  (radius)
	);

	ssh_mul #(
		.MW (MW),
		.PW (PW)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.x      (op_x),
		.y      (op_y),
		.done   (mul_done),
		.prod   (prod)
	);

	ssh_div #(
		.NW (ACC),
		.QW (QW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (dot_q),
		.den    (len_q),
		.done   (div_done),
		.quot   (quot)
	);

	always_comb begin
		e_ca = {c_q[axis_q][W-1], c_q[axis_q]} - {a_q[axis_q][W-1], a_q[axis_q]};
		e_cb = {c_q[axis_q][W-1], c_q[axis_q]} - {b_q[axis_q][W-1], b_q[axis_q]};
		e_d  = {b_q[axis_q][W-1], b_q[axis_q]} - {a_q[axis_q][W-1], a_q[axis_q]};
		e_cp = {c_q[axis_q][W-1], c_q[axis_q]} - {p_q[axis_q][W-1], p_q[axis_q]};
		m_ca = e_ca[W] ? (~e_ca + 1'b1) : e_ca;
		m_cb = e_cb[W] ? (~e_cb + 1'b1) : e_cb;
		m_d  = e_d[W] ? (~e_d + 1'b1) : e_d;
		m_cp = e_cp[W] ? (~e_cp + 1'b1) : e_cp;
		op_neg = 1'b0;
		case (job_q)
			J_R2: begin
				op_x = MW'(radius);
				op_y = MW'(radius);
			end
			J_SA: begin
				op_x = MW'(m_ca);
				op_y = MW'(m_ca);
			end
			J_SB: begin
				op_x = MW'(m_cb);
				op_y = MW'(m_cb);
			end
			J_LEN: begin
				op_x = MW'(m_d);
				op_y = MW'(m_d);
			end
			J_DOT: begin
				op_x = MW'(m_ca);
				op_y = MW'(m_d);
				op_neg = e_ca[W] ^ e_d[W];
			end
			J_P: begin
				op_x = MW'(tq_q);
				op_y = MW'(m_d);
			end
			J_SP: begin
				op_x = MW'(m_cp);
				op_y = MW'(m_cp);
			end
			default: begin
				op_x = '0;
				op_y = '0;
			end
		endcase
	end

	always_comb begin
		prod_ext = ACC'(prod);
		acc_next = op_neg ? (acc_q - prod_ext) : (acc_q + prod_ext);
		// The offset along the segment, truncated toward zero.
		off = prod[F +: W+1];
		p_next = e_d[W] ? ({a_q[axis_q][W-1], a_q[axis_q]} - off)
		                : ({a_q[axis_q][W-1], a_q[axis_q]} + off);
		last_axis = (job_q == J_R2) || (axis_q == 2'd2);
		// Projection is usable when the segment has length and 0 <= t <= 1.
		on_segment = (len_q != '0) && !acc_next[ACC-1] && (acc_next <= len_q);
		mul_start = (state_q == S_MUL);
		div_start = (state_q == S_DIV);
		out_free = !res_valid_q || result.ready;
		if (skip_q) begin
			flags.hit = 1'b0;
			flags.skipped = 1'b1;
			flags.point_valid = 1'b0;
		end else begin
			flags.hit = (sa_q < r2_q) || (sb_q < r2_q) || (point_q && (sp_q < r2_q));
			flags.skipped = 1'b0;
			flags.point_valid = point_q;
		end
	end

	assign seg.ready = (state_q == S_IDLE);
	assign result.valid = res_valid_q;
	assign result.hit = res_flags_q.hit;
	assign result.skipped = res_flags_q.skipped;
	assign result.point_valid = res_flags_q.point_valid;
	assign result.p_x = res_p_q[0];
	assign result.p_y = res_p_q[1];
	assign result.p_z = res_p_q[2];

	// Control state, the hit latch and the output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			job_q       <= J_R2;
			axis_q      <= '0;
			latch_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			// A new result may replace the one being transferred in the same cycle.
			if (state_q == S_DONE && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (seg.valid) begin
						job_q  <= J_R2;
						axis_q <= '0;
						state_q <= latch_q ? S_DONE : S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (mul_done) begin
						if (!last_axis) begin
							axis_q  <= axis_q + 2'd1;
							state_q <= S_MUL;
						end else begin
							axis_q <= '0;
							case (job_q)
								J_R2: begin
									job_q <= J_SA;
									state_q <= S_MUL;
								end
								J_SA: begin
									job_q <= J_SB;
									state_q <= S_MUL;
								end
								J_SB: begin
									job_q <= J_LEN;
									state_q <= S_MUL;
								end
								J_LEN: begin
									job_q <= J_DOT;
									state_q <= S_MUL;
								end
								J_DOT: begin
									state_q <= on_segment ? S_DIV : S_DONE;
								end
								J_P: begin
									job_q <= J_SP;
									state_q <= S_MUL;
								end
								default: begin
									state_q <= S_DONE;
								end
							endcase
						end
					end
				end
				S_DIV: begin
					state_q <= S_DWAIT;
				end
				S_DWAIT: begin
					if (div_done) begin
						job_q <= J_P;
						state_q <= S_MUL;
					end
				end
				S_DONE: begin
					if (out_free) begin
						latch_q <= latch_q | flags.hit;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (seg.valid) begin
					a_q[0] <= seg.a_x;
					a_q[1] <= seg.a_y;
					a_q[2] <= seg.a_z;
					b_q[0] <= seg.b_x;
					b_q[1] <= seg.b_y;
					b_q[2] <= seg.b_z;
					c_q[0] <= seg.c_x;
					c_q[1] <= seg.c_y;
					c_q[2] <= seg.c_z;
					skip_q  <= latch_q;
					point_q <= 1'b0;
					acc_q   <= '0;
				end
			end
			S_WAIT: begin
				if (mul_done) begin
					if (job_q == J_P) begin
						p_q[axis_q] <= p_next[W-1:0];
					end
					if (!last_axis) begin
						acc_q <= acc_next;
					end else begin
						acc_q <= '0;
						case (job_q)
							J_R2: r2_q <= acc_next;
							J_SA: sa_q <= acc_next;
							J_SB: sb_q <= acc_next;
							J_LEN: len_q <= acc_next;
							J_DOT: begin
								dot_q <= acc_next;
								point_q <= on_segment;
							end
							J_SP: sp_q <= acc_next;
							default: begin
							end
						endcase
					end
				end
			end
			S_DWAIT: begin
				if (div_done) begin
					tq_q <= quot;
				end
			end
			S_DONE: begin
				if (out_free) begin
					res_flags_q <= flags;
					for (int i = 0; i < 3; i++) begin
						res_p_q[i] <= flags.point_valid ? p_q[i] : '0;
					end
				end
			end
			default: begin
			end
		endcase
	end
endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the segment/sphere hit test.
module tb;
	import ssh_pkg::*;

	localparam int CW = 32;
	localparam int FB = 16;
	localparam logic signed [CW-1:0] CMAX = 32'sh7fffffff;
	localparam logic signed [CW-1:0] CMIN = 32'sh80000000;
	localparam logic signed [CW-1:0] ONE = 32'sh00010000;
	localparam logic [RAD_W-1:0] RADIUS_MAX = {RAD_W{1'b1}};
	localparam logic [APB_AW-1:0] ADDR_RADIUS = APB_AW'(REG_RADIUS) << 2;

	typedef struct {
		logic signed [CW-1:0] a[3];
		logic signed [CW-1:0] b[3];
		logic signed [CW-1:0] c[3];
	} segment_t;

	typedef struct {
		logic hit;
		logic skipped;
		logic point_valid;
		logic signed [CW-1:0] p[3];
	} outcome_t;

	typedef logic signed [127:0] wide_t;

	// Tracks the radius and the sticky hit latch, and predicts one outcome per segment.
	class hit_scoreboard;
		logic [RAD_W-1:0] radius;
		bit latched;
		outcome_t pending[$];
		int errors;

		function new();
			radius = RADIUS_RESET;
			latched = 0;
			errors = 0;
		endfunction

		function automatic wide_t dist2(wide_t p[3], wide_t c[3]);
			wide_t s;
			s = 0;
			for (int i = 0; i < 3; i++) s += (c[i] - p[i]) * (c[i] - p[i]);
			return s;
		endfunction

		function void note_segment(segment_t s);
			outcome_t o;
			wide_t av[3], bv[3], cv[3], dv[3], pv[3];
			wide_t r2, len2, dot, tq, mg;
			o.hit = 0;
			o.skipped = 0;
			o.point_valid = 0;
			for (int i = 0; i < 3; i++) o.p[i] = '0;
			if (latched) begin
				o.skipped = 1;
			end else begin
				r2 = wide_t'(radius) * wide_t'(radius);
				len2 = 0;
				dot = 0;
				for (int i = 0; i < 3; i++) begin
					av[i] = s.a[i];
					bv[i] = s.b[i];
					cv[i] = s.c[i];
					dv[i] = bv[i] - av[i];
					len2 += dv[i] * dv[i];
					dot += (cv[i] - av[i]) * dv[i];
				end
				// Strict test: a point on the sphere surface is not a hit.
				if (dist2(av, cv) < r2 || dist2(bv, cv) < r2) o.hit = 1;
				// The closest point exists only for a proper segment with 0 <= t <= 1.
				if (len2 != 0 && dot >= 0 && dot <= len2) begin
					o.point_valid = 1;
					tq = (dot <<< FB) / len2;
					for (int i = 0; i < 3; i++) begin
						mg = dv[i] < 0 ? -dv[i] : dv[i];
						mg = (tq * mg) >>> FB;
						pv[i] = dv[i] < 0 ? av[i] - mg : av[i] + mg;
						o.p[i] = pv[i][CW-1:0];
					end
					if (dist2(pv, cv) < r2) o.hit = 1;
				end
				if (o.hit) latched = 1;
			end
			pending.push_back(o);
		endfunction

		function void check_result(outcome_t r);
			outcome_t e;
			if (pending.size() == 0) begin
				$error("result transfer with no outstanding segment");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (r.hit !== e.hit) begin
				$error("hit: expected %0b, got %0b", e.hit, r.hit);
				errors++;
			end
			if (r.skipped !== e.skipped) begin
				$error("skipped: expected %0b, got %0b", e.skipped, r.skipped);
				errors++;
			end
			if (r.point_valid !== e.point_valid) begin
				$error("point_valid: expected %0b, got %0b", e.point_valid, r.point_valid);
				errors++;
			end
			for (int i = 0; i < 3; i++) begin
				if (r.p[i] !== e.p[i]) begin
					$error("p_%s: expected %0d, got %0d", i == 0 ? "x" : i == 1 ? "y" : "z",
						e.p[i], r.p[i]);
					errors++;
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata, prdata;

	// When set, neither side inserts idle cycles, so back-to-back transfers are exercised.
	bit calm;

	ssh_seg_if #(.W(CW)) seg_ch ();
	ssh_res_if #(.W(CW)) res_ch ();

	hit_scoreboard sb;

	segment_sphere_hit_test #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.seg(seg_ch),
		.result(res_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Safety net against a hung handshake.
	initial begin
		#40000000;
		$display("== FAIL ==");
		$finish;
	end

	// Register write: setup cycle, then access cycle. Called on a falling edge while idle.
	task automatic write_radius(logic [RAD_W-1:0] value);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = ADDR_RADIUS;
		pwdata = APB_DW'(value);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.radius = value;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Offers one segment after a random gap and waits for its transfer. Called on a falling edge.
	task automatic send_segment(segment_t s);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			seg_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		seg_ch.a_x = s.a[0]; seg_ch.a_y = s.a[1]; seg_ch.a_z = s.a[2];
		seg_ch.b_x = s.b[0]; seg_ch.b_y = s.b[1]; seg_ch.b_z = s.b[2];
		seg_ch.c_x = s.c[0]; seg_ch.c_y = s.c[1]; seg_ch.c_z = s.c[2];
		seg_ch.valid = 1'b1;
		do @(posedge clk); while (!seg_ch.ready);
		sb.note_segment(s);
		@(negedge clk);
		// The next call raises valid again at once when it has no gap.
		seg_ch.valid = 1'b0;
	endtask

	function automatic segment_t make_segment(
		logic signed [CW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz);
		segment_t s;
		s.a = '{ax, ay, az};
		s.b = '{bx, by, bz};
		s.c = '{cx, cy, cz};
		return s;
	endfunction

	// Either fully random coordinates, or a short segment with the center placed near
	// its line so that the projection often lands on the segment.
	function automatic segment_t random_segment();
		segment_t s;
		int k;
		logic signed [CW-1:0] span;
		if ($urandom_range(0, 9) < 4) begin
			for (int i = 0; i < 3; i++) begin
				s.a[i] = $urandom();
				s.b[i] = $urandom();
				s.c[i] = $urandom();
			end
		end else begin
			span = $urandom_range(0, 3) == 0 ? 32'sd4096 : 32'sd1048576;
			k = $urandom_range(0, 24) - 4;
			for (int i = 0; i < 3; i++) begin
				s.a[i] = $signed($urandom_range(0, 2 * span)) - span;
				s.b[i] = $urandom_range(0, 7) == 0 ? s.a[i] :
					$signed($urandom_range(0, 2 * span)) - span;
				s.c[i] = s.a[i] + ((s.b[i] - s.a[i]) * k) / 16 +
					$signed($urandom_range(0, 8192)) - 4096;
			end
		end
		return s;
	endfunction

	task automatic drain();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (5) @(negedge clk);
	endtask

	task automatic random_run(int count);
		for (int n = 0; n < count; n++) begin
			// Every so often switch between idle-free stretches and random gaps.
			if (n % 60 == 0) calm = ($urandom_range(0, 3) == 0);
			send_segment(random_segment());
		end
		calm = 0;
	endtask

	// Result side: a random stall before each result unless calm is set, then one checked transfer.
	initial begin
		outcome_t r;
		int stall;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				res_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ch.ready = 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			r.hit = res_ch.hit;
			r.skipped = res_ch.skipped;
			r.point_valid = res_ch.point_valid;
			r.p = '{res_ch.p_x, res_ch.p_y, res_ch.p_z};
			sb.check_result(r);
			@(negedge clk);
		end
	end

	initial begin
		sb = new();
		calm = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		seg_ch.valid = 1'b0;
		seg_ch.a_x = '0; seg_ch.a_y = '0; seg_ch.a_z = '0;
		seg_ch.b_x = '0; seg_ch.b_y = '0; seg_ch.b_z = '0;
		seg_ch.c_x = '0; seg_ch.c_y = '0; seg_ch.c_z = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// A zero radius can never produce a hit, so the latch stays clear and every
		// segment is tested in full.
		write_radius('0);

		// Coordinate extremes.
		send_segment(make_segment(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
		send_segment(make_segment(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
		send_segment(make_segment(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0, 0, 0));
		send_segment(make_segment(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
		send_segment(make_segment(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
		send_segment(make_segment(CMIN, CMAX, 0, CMAX, CMIN, 0, CMAX, CMAX, CMIN));
		// Degenerate segments: only the endpoint tests apply.
		send_segment(make_segment(5, 6, 7, 5, 6, 7, 0, 0, 0));
		send_segment(make_segment(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN));
		// Projection before A and past B.
		send_segment(make_segment(0, 0, 0, ONE, 0, 0, -5 * ONE, ONE, 0));
		send_segment(make_segment(0, 0, 0, ONE, 0, 0, 9 * ONE, 0, ONE));
		// Projection exactly on A, exactly on B, and in the middle.
		send_segment(make_segment(0, 0, 0, 4 * ONE, 0, 0, 0, 3 * ONE, 0));
		send_segment(make_segment(0, 0, 0, 4 * ONE, 0, 0, 4 * ONE, 3 * ONE, 0));
		send_segment(make_segment(-ONE, -ONE, -ONE, ONE, ONE, ONE, 0, 7, -3));
		// Segment running in the negative direction with an uneven fraction.
		send_segment(make_segment(3 * ONE, 2, -ONE, -7 * ONE, 5, ONE, 1, 2, 3));
		send_segment(make_segment(0, 0, 0, 3, 0, 0, 1, 100, 0));
		random_run(390);

		drain();
		write_radius(1);
		random_run(200);

		drain();
		write_radius($urandom_range(2, 255));
		random_run(200);

		// Back to 1.0: endpoints are 10 away, but the closest point is 0.5 from the
		// center, so this hit comes from the projection alone and sets the latch.
		drain();
		write_radius(RADIUS_RESET);
		send_segment(make_segment(-10 * ONE, 0, 0, 10 * ONE, 0, 0, 0, ONE / 2, 0));

		// From here on every segment must come back skipped.
		drain();
		write_radius(RADIUS_MAX);
		random_run(30);
		seg_ch.valid = 1'b0;

		while (sb.pending.size() != 0) @(negedge clk);
		repeat (300) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

[sim.f]
hdl/ssh_pkg.sv
hdl/ssh_if.sv
hdl/ssh_apb.sv
hdl/ssh_mul.sv
hdl/ssh_div.sv
hdl/segment_sphere_hit_test.sv
tb/sv/tb.sv
